// File: sv/mcpd_pkg.sv
// ----------------------------------------------------------------------------
// mcpd_pkg
// Shared types and constants for the multi-channel poll debouncer.
// ----------------------------------------------------------------------------
package mcpd_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 4;
  localparam int unsigned PIN_COUNT        = 4;
  localparam int unsigned POWER_CHANNEL    = 3;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned SAMPLES_W  = 8;
  localparam int unsigned DEB_TIME_W = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [INTERVAL_W-1:0] POLL_INTERVAL_RST = 16'd10;
  localparam logic [SAMPLES_W-1:0]  DEB_SAMPLES_RST   = 8'd3;
  localparam logic [DEB_TIME_W-1:0] DEB_TIME_RST      = 16'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLL_INTERVAL = 2'd0,
    REG_DEB_SAMPLES   = 2'd1,
    REG_DEB_TIME      = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_POLL  = 1'b0,
    CMD_START = 1'b1
  } cmd_e;

  // Per-word control handed to every channel
  typedef struct packed {
    logic                  start;
    logic                  poll;
    logic [TIME_W-1:0]     now_ms;
    logic [SAMPLES_W-1:0]  samples;
    logic [DEB_TIME_W-1:0] time_ms;
  } chan_ctrl_t;

  typedef struct packed {
    logic settled;
    logic changed;
  } chan_stat_t;

  typedef struct packed {
    logic start;
    logic poll;
    logic enabled;
  } gate_stat_t;

endpackage

// File: sv/multi_channel_poll_debouncer.sv
// ----------------------------------------------------------------------------
// multi_channel_poll_debouncer
// Polled switch debouncer with per-channel sample count and elapsed time.
// ----------------------------------------------------------------------------
// Takes one word per clock while in_stall_o is low and returns exactly one
// result word per input word: the word is held in an input register, the
// poll gate and every channel update run as combinational logic on it, and
// the result lands in an output register. The per-channel update (a 32-bit
// elapsed-time subtract and compare) sets the clock-to-clock path. An input
// word is still taken while a finished result waits in the output register;
// stall on the output side reaches the input side only once both registers
// are full. Configuration writes take effect at the next edge.
// ----------------------------------------------------------------------------
module multi_channel_poll_debouncer #(
  parameter int unsigned NUM_CHANNELS = mcpd_pkg::NUM_CHANNELS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [mcpd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mcpd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // input words
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 cmd_i,
  input  logic [mcpd_pkg::TIME_W-1:0]          now_ms_i,
  input  logic [mcpd_pkg::PIN_COUNT-1:0]       pin_levels_i,
  // result words
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 poll_taken_o,
  output logic [mcpd_pkg::PIN_COUNT-1:0]       stable_levels_o,
  output logic [mcpd_pkg::PIN_COUNT-1:0]       changed_mask_o,
  output logic                                 power_fail_o
);

  // configuration registers
  logic [mcpd_pkg::INTERVAL_W-1:0] poll_interval_q;
  logic [mcpd_pkg::SAMPLES_W-1:0]  deb_samples_q;
  logic [mcpd_pkg::DEB_TIME_W-1:0] deb_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_interval_q <= mcpd_pkg::POLL_INTERVAL_RST;
      deb_samples_q   <= mcpd_pkg::DEB_SAMPLES_RST;
      deb_time_q      <= mcpd_pkg::DEB_TIME_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mcpd_pkg::REG_POLL_INTERVAL: poll_interval_q <= cfg_data_i;
        mcpd_pkg::REG_DEB_SAMPLES:   deb_samples_q   <= cfg_data_i[mcpd_pkg::SAMPLES_W-1:0];
        mcpd_pkg::REG_DEB_TIME:      deb_time_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic                               in_valid_q, in_valid_d;
  logic                               in_cmd_q;
  logic [mcpd_pkg::TIME_W-1:0]        in_now_q;
  logic [mcpd_pkg::PIN_COUNT-1:0]     in_pins_q;
  logic                               in_accept;
  logic                               out_ready;
  logic                               fire;

  logic                               out_valid_q, out_valid_d;
  logic                               poll_taken_q;
  logic [mcpd_pkg::PIN_COUNT-1:0]     stable_q, stable_d;
  logic [mcpd_pkg::PIN_COUNT-1:0]     changed_q, changed_d;
  logic                               power_fail_q, power_fail_d;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_cmd_q  <= cmd_i;
      in_now_q  <= now_ms_i;
      in_pins_q <= pin_levels_i;
    end
  end

  // poll gate
  mcpd_pkg::gate_stat_t gate_stat;

  mcpd_poll_gate u_gate (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .cmd_i      (in_cmd_q),
    .now_ms_i   (in_now_q),
    .interval_i (poll_interval_q),
    .stat_o     (gate_stat)
  );

  // channels
  mcpd_pkg::chan_ctrl_t              chan_ctrl;
  logic [NUM_CHANNELS-1:0]           settled_vec;
  logic [NUM_CHANNELS-1:0]           changed_vec;

  assign chan_ctrl.start   = gate_stat.start;
  assign chan_ctrl.poll    = gate_stat.poll;
  assign chan_ctrl.now_ms  = in_now_q;
  assign chan_ctrl.samples = deb_samples_q;
  assign chan_ctrl.time_ms = deb_time_q;

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
    logic                 pin;
    mcpd_pkg::chan_stat_t stat;

    // channels without a pin read low
    if (g < mcpd_pkg::PIN_COUNT) begin : g_pin
      assign pin = in_pins_q[g];
    end else begin : g_nopin
      assign pin = 1'b0;
    end

    mcpd_channel u_chan (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (chan_ctrl),
      .pin_i  (pin),
      .stat_o (stat)
    );

    assign settled_vec[g] = stat.settled;
    assign changed_vec[g] = stat.changed;
  end

  for (genvar b = 0; b < mcpd_pkg::PIN_COUNT; b++) begin : g_outbit
    if (b < NUM_CHANNELS) begin : g_used
      assign stable_d[b]  = settled_vec[b];
      assign changed_d[b] = changed_vec[b];
    end else begin : g_unused
      assign stable_d[b]  = 1'b0;
      assign changed_d[b] = 1'b0;
    end
  end

  if (NUM_CHANNELS > mcpd_pkg::POWER_CHANNEL) begin : g_pfail
    assign power_fail_d = changed_vec[mcpd_pkg::POWER_CHANNEL] &&
                          !settled_vec[mcpd_pkg::POWER_CHANNEL];
  end else begin : g_no_pfail
    assign power_fail_d = 1'b0;
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      poll_taken_q <= gate_stat.poll;
      stable_q     <= stable_d;
      changed_q    <= changed_d;
      power_fail_q <= power_fail_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign poll_taken_o    = poll_taken_q;
  assign stable_levels_o = stable_q;
  assign changed_mask_o  = changed_q;
  assign power_fail_o    = power_fail_q;

  // power fail only on a channel that just settled low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && power_fail_o) |-> (changed_mask_o[mcpd_pkg::POWER_CHANNEL] &&
                                       !stable_levels_o[mcpd_pkg::POWER_CHANNEL]))
    else $error("power fail without channel settling low");

  // levels change only on an accepted poll
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (changed_mask_o != '0)) |-> poll_taken_o)
    else $error("changed mask set on a word that was not a taken poll");

  // a processed word always reaches the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed word lost");

  // a poll can only be taken once armed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    gate_stat.poll |-> gate_stat.enabled)
    else $error("poll taken while not armed");

endmodule

// File: sv/mcpd_poll_gate.sv
// ----------------------------------------------------------------------------
// mcpd_poll_gate
// Arming flag and poll interval check against the last start or accepted poll time.
// ----------------------------------------------------------------------------
module mcpd_poll_gate (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             fire_i,
  input  logic                             cmd_i,
  input  logic [mcpd_pkg::TIME_W-1:0]      now_ms_i,
  input  logic [mcpd_pkg::INTERVAL_W-1:0]  interval_i,
  output mcpd_pkg::gate_stat_t             stat_o
);

  logic                          enabled_q, enabled_d;
  logic [mcpd_pkg::TIME_W-1:0]   last_q, last_d;
  logic [mcpd_pkg::TIME_W-1:0]   since_last;
  logic                          is_start;
  logic                          poll_ok;

  assign is_start   = (cmd_i == mcpd_pkg::CMD_START);
  assign since_last = now_ms_i - last_q;
  assign poll_ok    = !is_start && enabled_q &&
                      (since_last >= {{(mcpd_pkg::TIME_W-mcpd_pkg::INTERVAL_W){1'b0}},
                                      interval_i});

  always_comb begin
    enabled_d = enabled_q;
    last_d    = last_q;
    if (fire_i && is_start) begin
      enabled_d = 1'b1;
      last_d    = now_ms_i;
    end else if (fire_i && poll_ok) begin
      last_d = now_ms_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      last_q    <= '0;
    end else begin
      enabled_q <= enabled_d;
      last_q    <= last_d;
    end
  end

  assign stat_o.start   = fire_i && is_start;
  assign stat_o.poll    = fire_i && poll_ok;
  assign stat_o.enabled = enabled_q;

endmodule

// File: sv/mcpd_channel.sv
// ----------------------------------------------------------------------------
// mcpd_channel
// State and update of one debounced channel: sample counter and change time.
// ----------------------------------------------------------------------------
module mcpd_channel (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mcpd_pkg::chan_ctrl_t  ctrl_i,
  input  logic                  pin_i,
  output mcpd_pkg::chan_stat_t  stat_o
);

  logic                                prev_q, prev_d;
  logic                                cand_q, cand_d;
  logic                                settled_q, settled_d;
  logic [mcpd_pkg::TIME_W-1:0]         change_q, change_d;
  logic [mcpd_pkg::SAMPLES_W-1:0]      count_q, count_d;
  logic [mcpd_pkg::TIME_W-1:0]         elapsed;
  logic                                changed;

  always_comb begin
    prev_d    = prev_q;
    cand_d    = cand_q;
    settled_d = settled_q;
    change_d  = change_q;
    count_d   = count_q;
    changed   = 1'b0;
    elapsed   = ctrl_i.now_ms - change_q;
    if (ctrl_i.start) begin
      prev_d    = pin_i;
      cand_d    = pin_i;
      settled_d = pin_i;
      change_d  = '0;
      count_d   = '0;
    end else if (ctrl_i.poll) begin
      if (pin_i != prev_q) begin
        cand_d   = pin_i;
        change_d = ctrl_i.now_ms;
        count_d  = '0;
      end else if (count_q < ctrl_i.samples) begin
        count_d = count_q + 1'b1;
      end
      elapsed = ctrl_i.now_ms - change_d;
      // accept the candidate once both count and time thresholds are met
      if ((count_d >= ctrl_i.samples) &&
          (elapsed >= {{(mcpd_pkg::TIME_W-mcpd_pkg::DEB_TIME_W){1'b0}}, ctrl_i.time_ms}) &&
          (cand_d != settled_q)) begin
        settled_d = cand_d;
        changed   = 1'b1;
      end
      prev_d = pin_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= 1'b1;
      cand_q    <= 1'b1;
      settled_q <= 1'b1;
      change_q  <= '0;
      count_q   <= '0;
    end else begin
      prev_q    <= prev_d;
      cand_q    <= cand_d;
      settled_q <= settled_d;
      change_q  <= change_d;
      count_q   <= count_d;
    end
  end

  assign stat_o.settled = settled_d;
  assign stat_o.changed = changed;

endmodule
